[design/okl_pkg.sv]
`timescale 1ns / 1ps

package okl_pkg;

  // Field widths of one transaction on either side.
  localparam int OP_BITS     = 2;
  localparam int KEY_W       = 16;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  // Input tdata layout: operation, then key, padded to whole bytes.
  localparam int IN_OP_LSB   = 0;
  localparam int IN_KEY_LSB  = IN_OP_LSB + OP_BITS;
  localparam int IN_USED     = IN_KEY_LSB + KEY_W;
  localparam int IN_TDATA_W  = ((IN_USED + 7) / 8) * 8;

  // Output tdata layout: status, count, head key, tail key, empty flag.
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_COUNT_LSB  = OUT_STATUS_LSB + STATUS_BITS;
  localparam int OUT_HEAD_LSB   = OUT_COUNT_LSB + COUNT_BITS;
  localparam int OUT_TAIL_LSB   = OUT_HEAD_LSB + KEY_W;
  localparam int OUT_EMPTY_LSB  = OUT_TAIL_LSB + KEY_W;
  localparam int OUT_USED       = OUT_EMPTY_LSB + 1;
  localparam int OUT_TDATA_W    = ((OUT_USED + 7) / 8) * 8;

  typedef logic [OP_BITS-1:0]     op_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH_RD  = 9'b000000010,
    S_SRCH_CMP = 9'b000000100,
    S_SHF_RD   = 9'b000001000,
    S_SHF_WR   = 9'b000010000,
    S_FIX_RD   = 9'b000100000,
    S_FIX_HEAD = 9'b001000000,
    S_FIX_TAIL = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

endpackage

[design/ordered_key_list.sv]
`timescale 1ns / 1ps
// Push, clear and unknown codes go from acceptance to the result step and then to the output register.
// Remove reads and compares the key memory one entry at a time to find the match and then moves each
// later entry down one slot with a read step and a write step, then rereads head and tail.
// One transaction is in work at a time: a new one is accepted only after the result of the last one
// has moved into the output register, and a stalled result holds off the next acceptance until it is taken.
// Reset (rst, synchronous, active high) empties the list; the key memory itself is not cleared.

module ordered_key_list import okl_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata fields from bit 0: operation[1:0], key[17:2], zero padding.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // m_tdata fields from bit 0: status[1:0], count[6:2], head_key[22:7],
  // tail_key[38:23], is_empty[39].
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Only the low KEY_BITS of a key take part, and no more than the port carries.
  localparam int SB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [IW-1:0]   idx, idx_next;
  logic [SB-1:0]   key;
  logic [SB-1:0]   head, tail;
  status_t         status, status_next;
  logic            accept;

  // Key memory: one write and one registered read per cycle.
  logic [SB-1:0]   mem [CAPACITY];
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [SB-1:0]   wr_data;
  logic [IW-1:0]   rd_addr;
  logic [SB-1:0]   rdata;

  logic [SB-1:0]   in_key;
  op_t             in_op;
  logic [CW-1:0]   idx_plus1;
  logic            out_free;
  logic [OUT_TDATA_W-1:0] result_word;

  assign in_op     = s_tdata[IN_OP_LSB +: OP_BITS];
  assign in_key    = SB'(s_tdata[IN_KEY_LSB +: KEY_W]);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign idx_plus1 = CW'(idx) + 1'b1;
  // The result stage may load when the output register is empty or being drained.
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Memory read address follows the sequencer step.
  always_comb begin
    unique case (state)
      S_SHF_RD:   rd_addr = IW'(idx_plus1);
      S_FIX_RD:   rd_addr = '0;
      S_FIX_HEAD: rd_addr = IW'(count - 1'b1);
      default:    rd_addr = idx;
    endcase
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    status_next = status;
    wr_en       = 1'b0;
    wr_addr     = IW'(count);
    wr_data     = in_key;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = ST_DONE;
          idx_next    = '0;
          state_next  = S_RESULT;
          case (in_op)
            OP_PUSH: begin
              if (count == CW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                // A push writes the slot just past the tail.
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                status_next = ST_NOT_FOUND;
              end else begin
                state_next = S_SRCH_RD;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
              // An unused operation code leaves the list as it is.
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rdata == key) begin
          // Earliest match found at idx; close the gap from here.
          state_next = S_SHF_RD;
        end else if (CW'(idx) == count - 1'b1) begin
          status_next = ST_NOT_FOUND;
          state_next  = S_RESULT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SHF_RD: begin
        if (idx_plus1 < count) begin
          state_next = S_SHF_WR;
        end else begin
          count_next = count - 1'b1;
          state_next = S_FIX_RD;
        end
      end
      S_SHF_WR: begin
        // Move the entry above down into slot idx.
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = rdata;
        idx_next   = idx + 1'b1;
        state_next = S_SHF_RD;
      end
      S_FIX_RD: begin
        state_next = S_FIX_HEAD;
      end
      S_FIX_HEAD: begin
        state_next = S_FIX_TAIL;
      end
      S_FIX_TAIL: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // Key, status and the cached head and tail keys.
  always_ff @(posedge clk) begin
    status <= status_next;
    if (accept) begin
      key <= in_key;
    end
    if (state == S_IDLE && accept && in_op == OP_PUSH && count != CW'(CAPACITY)) begin
      tail <= in_key;
      if (count == '0) begin
        head <= in_key;
      end
    end
    if (state == S_FIX_HEAD) begin
      head <= rdata;
    end
    if (state == S_FIX_TAIL) begin
      tail <= rdata;
    end
  end

  // Result word: an empty list shows zero head and tail keys.
  always_comb begin
    result_word                                = '0;
    result_word[OUT_STATUS_LSB +: STATUS_BITS] = status;
    result_word[OUT_COUNT_LSB +: COUNT_BITS]   = COUNT_BITS'(count);
    if (count == '0) begin
      result_word[OUT_EMPTY_LSB] = 1'b1;
    end else begin
      result_word[OUT_HEAD_LSB +: KEY_W] = KEY_W'(head);
      result_word[OUT_TAIL_LSB +: KEY_W] = KEY_W'(tail);
    end
  end

  // Output register: loaded from the result step, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      m_tdata <= result_word;
    end
  end

endmodule

[design/okl_checker.sv]
`timescale 1ns / 1ps

module okl_checker import okl_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The empty flag agrees with a count of zero.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_EMPTY_LSB] == (m_tdata[OUT_COUNT_LSB +: COUNT_BITS] == '0)))
    else $error("empty flag and count disagree");

  // An empty list shows zero head and tail keys.
  a_zero_keys: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_EMPTY_LSB] |->
      m_tdata[OUT_HEAD_LSB +: KEY_W] == '0 && m_tdata[OUT_TAIL_LSB +: KEY_W] == '0)
    else $error("empty list shows nonzero keys");

  // One transaction in work at a time: input side closes after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind ordered_key_list okl_checker u_okl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import okl_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int KEY_WIDTH   = 16;
  localparam int SETTLE_CYCS = 2 * LIST_DEPTH + 16;
  localparam int DRAIN_LIMIT = 20000;

  // One reply as the list reports it after each transaction.
  typedef struct packed {
    status_t                 status;
    logic [COUNT_BITS-1:0]   count;
    logic [KEY_WIDTH-1:0]    head_key;
    logic [KEY_WIDTH-1:0]    tail_key;
    logic                    is_empty;
  } list_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Shadow copy of the list contents, head first, and the replies still owed by the block.
  logic [KEY_WIDTH-1:0] list_shadow[$];
  list_reply_t          owed_replies[$];

  int  error_count   = 0;
  int  reply_count   = 0;
  int  n_stored      = 0;
  int  n_refused     = 0;
  int  n_matched     = 0;
  int  n_missed      = 0;
  int  n_cleared     = 0;
  int  n_odd_code    = 0;
  bit  src_no_idle   = 1'b0;
  bit  sink_no_idle  = 1'b0;

  ordered_key_list #(
    .CAPACITY (LIST_DEPTH),
    .KEY_BITS (KEY_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int draw_wait(bit no_idle);
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Applies one operation to the shadow list and queues the reply it must produce.
  function automatic void apply_list_op(op_t op, logic [KEY_WIDTH-1:0] key);
    list_reply_t r;
    int          hit;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUSH: begin
        if (list_shadow.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
          n_refused++;
        end else begin
          list_shadow.push_back(key);
          n_stored++;
        end
      end
      OP_REMOVE: begin
        hit = -1;
        for (int i = 0; i < list_shadow.size(); i++) begin
          if (list_shadow[i] == key) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
          n_missed++;
        end else begin
          list_shadow.delete(hit);
          n_matched++;
        end
      end
      OP_CLEAR: begin
        list_shadow.delete();
        n_cleared++;
      end
      default: n_odd_code++;
    endcase
    r.count = COUNT_BITS'(list_shadow.size());
    if (list_shadow.size() == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.head_key = list_shadow[0];
      r.tail_key = list_shadow[list_shadow.size()-1];
    end
    owed_replies.push_back(r);
  endfunction

  // Offers one transaction after a random gap and holds it until the block takes it.
  task automatic send_op(op_t op, logic [KEY_WIDTH-1:0] key);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    gap  = draw_wait(src_no_idle);
    word = '0;
    word[IN_OP_LSB +: OP_BITS] = op;
    word[IN_KEY_LSB +: KEY_W]  = key;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    apply_list_op(op, key);
  endtask

  // Receiving side: random stalls, then each reply is checked against the oldest owed one.
  initial begin : reply_checker
    logic [OUT_TDATA_W-1:0] word;
    list_reply_t            exp_r;
    int                     stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(sink_no_idle);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      word = m_tdata;
      reply_count++;
      if (owed_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing owed, data %h", word));
      end else begin
        exp_r = owed_replies.pop_front();
        if (word[OUT_STATUS_LSB +: STATUS_BITS] !== exp_r.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    word[OUT_STATUS_LSB +: STATUS_BITS], exp_r.status));
        if (word[OUT_COUNT_LSB +: COUNT_BITS] !== exp_r.count)
          report_mismatch($sformatf("count got %0d expected %0d",
                                    word[OUT_COUNT_LSB +: COUNT_BITS], exp_r.count));
        if (word[OUT_HEAD_LSB +: KEY_W] !== exp_r.head_key)
          report_mismatch($sformatf("head_key got %h expected %h",
                                    word[OUT_HEAD_LSB +: KEY_W], exp_r.head_key));
        if (word[OUT_TAIL_LSB +: KEY_W] !== exp_r.tail_key)
          report_mismatch($sformatf("tail_key got %h expected %h",
                                    word[OUT_TAIL_LSB +: KEY_W], exp_r.tail_key));
        if (word[OUT_EMPTY_LSB] !== exp_r.is_empty)
          report_mismatch($sformatf("is_empty got %b expected %b",
                                    word[OUT_EMPTY_LSB], exp_r.is_empty));
      end
    end
  end

  // Remove and the unused operation code on a list that holds nothing.
  task automatic test_empty_list();
    send_op(OP_REMOVE, 16'h0000);
    send_op(op_t'(2'd3), 16'hFFFF);
  endtask

  // Extreme keys, a duplicate, removal of the earliest copy, a miss, and clear.
  task automatic test_push_remove();
    send_op(OP_PUSH, 16'h0000);
    send_op(OP_PUSH, 16'hFFFF);
    send_op(OP_PUSH, 16'h0000);
    send_op(OP_REMOVE, 16'h0000);
    send_op(OP_REMOVE, 16'h1234);
    send_op(OP_CLEAR, 16'hABCD);
  endtask

  // Fill the list to capacity, then one push that must be refused.
  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH; i++)
      send_op(OP_PUSH, 16'hA5A5 ^ KEY_WIDTH'(i * 16'h1111));
    send_op(OP_PUSH, 16'h5A5A);
  endtask

  // Each segment draws a push share that favours filling, balance or draining, so both full and empty lists recur.
  // Keys mostly come from a small pool or from the list itself so removes usually hit
  // and duplicates are common.
  task automatic test_random_traffic(int n_items);
    logic [KEY_WIDTH-1:0] key_pool[6];
    logic [KEY_WIDTH-1:0] key;
    int                   push_pct;
    int                   roll;
    int                   sent;
    foreach (key_pool[i]) key_pool[i] = KEY_WIDTH'($urandom_range(0, 65535));
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 50;
        default: push_pct = 25;
      endcase
      src_no_idle  = ($urandom_range(0, 3) == 0);
      sink_no_idle = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < 50 && sent < n_items; j++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60)
          key = key_pool[$urandom_range(0, 5)];
        else
          key = KEY_WIDTH'($urandom_range(0, 65535));
        if (roll < 3) begin
          send_op(OP_CLEAR, key);
        end else if (roll < 5) begin
          send_op(op_t'(2'd3), key);
        end else if ($urandom_range(0, 99) < push_pct) begin
          send_op(OP_PUSH, key);
        end else begin
          if (list_shadow.size() != 0 && $urandom_range(0, 99) < 70)
            key = list_shadow[$urandom_range(0, list_shadow.size() - 1)];
          send_op(OP_REMOVE, key);
        end
        sent++;
      end
    end
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
  endtask

  initial begin : stimulus
    int drain_cycles;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_push_remove();
    test_full_list();
    test_random_traffic(700);
    s_tvalid <= 1'b0;
    drain_cycles = 0;
    while (owed_replies.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCS) @(posedge clk);
    if (owed_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", owed_replies.size()));
    $display("Checked %0d replies: %0d keys stored, %0d pushes refused on a full list,",
             reply_count, n_stored, n_refused);
    $display("%0d removes matched, %0d removes missed, %0d clears, %0d unused codes.",
             n_matched, n_missed, n_cleared, n_odd_code);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Far beyond the slowest legal run: every transaction waiting out both idle
  // draws and the longest remove.
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
design/okl_pkg.sv
design/ordered_key_list.sv
design/okl_checker.sv
verif/tb_top.sv
